// File: rtl/svm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sample voice mixer package
// Shared widths, sizes, mode and status codes, and the command and status
// structures between the mixer controller and datapath.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int VOICE_SLOTS   = 5;
    localparam int SOUND_ENTRIES = 32;
    localparam int SAMPLE_WORDS  = 65536;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 5;
    localparam int GAIN_W   = 16;
    localparam int ADDR_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 17;
    localparam int STATUS_W = 2;
    localparam int BUSY_W   = 3;

    localparam int VIDX_W    = $clog2(VOICE_SLOTS);
    localparam int SID_W     = $clog2(SOUND_ENTRIES);
    localparam int SAMPLE_AW = $clog2(SAMPLE_WORDS);
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(65536);

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_TICK      = 2'd0;
    localparam t_mode MODE_START     = 2'd1;
    localparam t_mode MODE_WR_SAMPLE = 2'd2;
    localparam t_mode MODE_WR_SOUND  = 2'd3;

    localparam t_status ST_DONE     = 2'd0;
    localparam t_status ST_DROPPED  = 2'd1;
    localparam t_status ST_REJECTED = 2'd2;
    localparam t_status ST_MUTED    = 2'd3;

    typedef struct packed {
        logic              accept;
        logic              issue;
        logic [VIDX_W-1:0] vidx;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic tick_run;
        logic pipe_busy;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/svm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer input channel
// Valid/ready channel that carries one mixer command item.
// ----------------------------------------------------------------------------
interface svm_in_if;
    logic                           valid;
    logic                           ready;
    logic [svm_pkg::MODE_W-1:0]     mode;
    logic [svm_pkg::ID_W-1:0]       sound_id;
    logic [svm_pkg::GAIN_W-1:0]     gain;
    logic [svm_pkg::ADDR_W-1:0]     address;
    logic signed [svm_pkg::SAMPLE_W-1:0] sample_value;
    logic [svm_pkg::LEN_W-1:0]      sound_length;

    modport source (output valid, mode, sound_id, gain, address, sample_value,
                    sound_length, input ready);
    modport sink (input valid, mode, sound_id, gain, address, sample_value,
                  sound_length, output ready);
endinterface
`default_nettype wire

// File: rtl/svm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer output channel
// Valid/ready channel that carries one mixer result item.
// ----------------------------------------------------------------------------
interface svm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [svm_pkg::SAMPLE_W-1:0] mixed_sample;
    logic [svm_pkg::STATUS_W-1:0]        status;
    logic [svm_pkg::BUSY_W-1:0]          voices_busy;

    modport source (output valid, mixed_sample, status, voices_busy, input ready);
    modport sink (input valid, mixed_sample, status, voices_busy, output ready);
endinterface
`default_nettype wire

// File: rtl/sample_voice_mixer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sample voice mixer
// Five-slot sample playback mixer: loads samples and a sound table, starts
// voices and gives one mixed output sample per tick.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// i_in      sink       mode, sound_id, gain, address, sample_value, sound_length
// o_out     source     mixed_sample, status, voices_busy
// cfg       write      sound_enable, one bit
//
// Writes, starts and muted ticks go from the idle state straight to the finish
// state. A playing tick first steps the five voice slots in turn through one
// sample memory read port and one shared multiplier, then drains the pipeline,
// and the finish state loads the output register; back in idle the next
// transaction can be taken. Reset is synchronous and needs no clearing pass.
// A new transaction is taken while the previous result waits at the output
// register; a finished item stalls until that register is free.
// ----------------------------------------------------------------------------
module sample_voice_mixer_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data,
    svm_in_if.sink    i_in,
    svm_out_if.source o_out
);
    import svm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    svm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    svm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_mode         (i_in.mode),
        .i_sound_id     (i_in.sound_id),
        .i_gain         (i_in.gain),
        .i_address      (i_in.address),
        .i_sample_value (i_in.sample_value),
        .i_sound_length (i_in.sound_length),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_mixed_sample (o_out.mixed_sample),
        .o_status       (o_out.status),
        .o_voices_busy  (o_out.voices_busy)
    );

endmodule
`default_nettype wire

// File: rtl/svm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer controller
// State machine that accepts items, steps the datapath through the voice
// slots on a tick while sound is enabled, waits for the multiply pipeline and hands out the result.
// ----------------------------------------------------------------------------
module svm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    input  wire svm_pkg::t_stat i_stat,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output svm_pkg::t_cmd      o_cmd
);
    import svm_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ISSUE  = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(VOICE_SLOTS - 1);

    logic [1:0]        r_state, n_state;
    logic [VIDX_W-1:0] r_vidx, n_vidx;
    logic              r_out_valid, n_out_valid;
    logic              accept;
    logic              load_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign load_out   = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_vidx  = r_vidx;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_vidx  = '0;
                    n_state = i_stat.tick_run ? S_ISSUE : S_FINISH;
                end
            end
            S_ISSUE: begin
                if (r_vidx == VIDX_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_vidx = r_vidx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vidx      <= n_vidx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cmd.accept    = accept;
    assign o_cmd.issue     = (r_state == S_ISSUE);
    assign o_cmd.vidx      = r_vidx;
    assign o_cmd.load_out  = load_out;

endmodule
`default_nettype wire

// File: rtl/svm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer datapath
// Sample memory, sound table, voice slot registers, the shared gain
// multiplier with its accumulator, and the result register.
// ----------------------------------------------------------------------------
module svm_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic                             i_cfg_wr_data,
    input  wire logic [svm_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [svm_pkg::ID_W-1:0]         i_sound_id,
    input  wire logic [svm_pkg::GAIN_W-1:0]       i_gain,
    input  wire logic [svm_pkg::ADDR_W-1:0]       i_address,
    input  wire logic signed [svm_pkg::SAMPLE_W-1:0] i_sample_value,
    input  wire logic [svm_pkg::LEN_W-1:0]        i_sound_length,
    input  wire svm_pkg::t_cmd                    i_cmd,
    output svm_pkg::t_stat                        o_stat,
    output logic signed [svm_pkg::SAMPLE_W-1:0]   o_mixed_sample,
    output logic [svm_pkg::STATUS_W-1:0]          o_status,
    output logic [svm_pkg::BUSY_W-1:0]            o_voices_busy
);
    import svm_pkg::*;

    logic                r_sound_enable;
    logic [SAMPLE_W-1:0] r_mem [SAMPLE_WORDS];

    logic [SOUND_ENTRIES-1:0] r_tbl_vld;
    logic [ADDR_W-1:0]        r_tbl_start [SOUND_ENTRIES];
    logic [LEN_W-1:0]         r_tbl_size  [SOUND_ENTRIES];

    logic [VOICE_SLOTS-1:0] r_vact;
    logic [ADDR_W-1:0]      r_vaddr [VOICE_SLOTS];
    logic [LEN_W-1:0]       r_vrem  [VOICE_SLOTS];
    logic [GAIN_W-1:0]      r_vgain [VOICE_SLOTS];
    logic [BUSY_W-1:0]      r_busy;

    logic                       r_rd_en;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic [GAIN_W-1:0]          r_rd_gain;
    logic                       r_prod_en;
    logic signed [PROD_W-1:0]   r_prod;
    logic [SAMPLE_W-1:0]        r_acc;
    t_status                    r_item_status;

    logic [SAMPLE_W-1:0] r_out_mixed;
    t_status             r_out_status;
    logic [BUSY_W-1:0]   r_out_busy;

    logic [SID_W-1:0]    sid;
    logic [ADDR_W-1:0]   tbl_start;
    logic [LEN_W-1:0]    tbl_size;
    logic [LEN_W-1:0]    len_sat;
    logic                free_found;
    logic [VIDX_W-1:0]   free_idx;
    t_status             item_status;
    logic                start_ok;
    logic                mute_tick;
    logic                wr_sample;
    logic                wr_sound;

    logic                cur_act;
    logic [LEN_W-1:0]    cur_rem;
    logic [ADDR_W-1:0]   cur_addr;
    logic                rd_take;
    logic [LEN_W-1:0]    new_rem;
    logic                voice_free;
    logic signed [PROD_W-1:0] prod_adj;

    assign sid       = i_sound_id[SID_W-1:0];
    assign tbl_start = r_tbl_vld[sid] ? r_tbl_start[sid] : '0;
    assign tbl_size  = r_tbl_vld[sid] ? r_tbl_size[sid]  : '0;
    assign len_sat   = (i_sound_length > LEN_MAX) ? LEN_MAX : i_sound_length;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = 0; v < VOICE_SLOTS; v++) begin
            if (!free_found && !r_vact[v]) begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(v);
            end
        end
    end

    always_comb begin
        item_status = ST_DONE;
        if (i_mode == MODE_START) begin
            priority if (!r_sound_enable) begin
                item_status = ST_MUTED;
            end else if (i_gain == '0) begin
                item_status = ST_REJECTED;
            end else if (!free_found) begin
                item_status = ST_DROPPED;
            end
        end
    end

    assign start_ok  = i_cmd.accept && (i_mode == MODE_START) && r_sound_enable &&
                       (i_gain != '0) && free_found;
    assign mute_tick = i_cmd.accept && (i_mode == MODE_TICK) && !r_sound_enable;
    assign wr_sample = i_cmd.accept && (i_mode == MODE_WR_SAMPLE);
    assign wr_sound  = i_cmd.accept && (i_mode == MODE_WR_SOUND);

    assign cur_act    = r_vact[i_cmd.vidx];
    assign cur_rem    = r_vrem[i_cmd.vidx];
    assign cur_addr   = r_vaddr[i_cmd.vidx];
    assign rd_take    = cur_act && (cur_rem != '0);
    assign new_rem    = rd_take ? cur_rem - 1'b1 : cur_rem;
    assign voice_free = cur_act && (new_rem == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_sound_enable <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_sample) begin
            r_mem[i_address[SAMPLE_AW-1:0]] <= i_sample_value;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[cur_addr[SAMPLE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
        end else if (wr_sound) begin
            r_tbl_vld[sid] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_sound) begin
            r_tbl_start[sid] <= i_address;
            r_tbl_size[sid]  <= len_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vact <= '0;
            r_busy <= '0;
        end else if (start_ok) begin
            r_vact[free_idx] <= 1'b1;
            r_busy           <= r_busy + 1'b1;
        end else if (mute_tick) begin
            r_vact <= '0;
            r_busy <= '0;
        end else if (i_cmd.issue && voice_free) begin
            r_vact[i_cmd.vidx] <= 1'b0;
            r_busy             <= r_busy - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_ok) begin
            r_vaddr[free_idx] <= tbl_start;
            r_vrem[free_idx]  <= tbl_size;
            r_vgain[free_idx] <= i_gain;
        end else if (i_cmd.issue && rd_take) begin
            r_vaddr[i_cmd.vidx] <= cur_addr + 1'b1;
            r_vrem[i_cmd.vidx]  <= new_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en   <= 1'b0;
            r_prod_en <= 1'b0;
        end else begin
            r_rd_en   <= i_cmd.issue && rd_take;
            r_prod_en <= r_rd_en;
        end
    end

    assign prod_adj = r_prod + (r_prod[PROD_W-1] ? PROD_W'(65535) : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_gain <= r_vgain[i_cmd.vidx];
        end
        r_prod <= PROD_W'(r_rd_data) * $signed({1'b0, r_rd_gain});
        if (i_cmd.accept) begin
            r_acc         <= '0;
            r_item_status <= item_status;
        end else if (r_prod_en) begin
            r_acc <= r_acc + prod_adj[SAMPLE_W+16-1:16];
        end
        if (i_cmd.load_out) begin
            r_out_mixed  <= r_acc;
            r_out_status <= r_item_status;
            r_out_busy   <= r_busy;
        end
    end

    assign o_stat.tick_run  = (i_mode == MODE_TICK) && r_sound_enable;
    assign o_stat.pipe_busy = r_rd_en || r_prod_en;
    assign o_mixed_sample   = r_out_mixed;
    assign o_status         = r_out_status;
    assign o_voices_busy    = r_out_busy;

endmodule
`default_nettype wire
